>>> sv/jwst_pkg.sv
// Shared types and constants for the joint waypoint segment timer.
package jwst_pkg;

  localparam int MAX_JOINTS = 7;
  localparam int POS_W      = 16;
  localparam int RATE_W     = 16;
  localparam int FRAC_BITS  = 12;
  localparam int PROD_W     = POS_W + RATE_W;
  localparam int SEG_W      = 20;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int S_TDATA_W  = MAX_JOINTS * POS_W;
  localparam int M_TDATA_W  = 56;

  localparam logic [RATE_W-1:0]    RATE_RESET    = 16'd4096;
  localparam logic [SEG_W-1:0]     MIN_SEG_RESET = 20'd41;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEG   = 3'd7;

  // Live configuration seen by the datapath.
  typedef struct packed {
    logic [MAX_JOINTS-1:0][RATE_W-1:0] inv_rate;
    logic [SEG_W-1:0]                  min_seg;
  } cfg_t;

  // One waypoint after the difference stage: absolute joint moves.
  typedef struct packed {
    logic                             first;
    logic [MAX_JOINTS-1:0][POS_W-1:0] abs_delta;
  } delta_item_t;

endpackage

>>> sv/jwst_cfg_regs.sv
// Configuration register file: inverse joint rates and minimum segment time.
module jwst_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [jwst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jwst_pkg::CFG_DATA_W-1:0] cfg_data,
  output jwst_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < jwst_pkg::MAX_JOINTS; j++) begin
        cfg.inv_rate[j] <= jwst_pkg::RATE_RESET;
      end
      cfg.min_seg <= jwst_pkg::MIN_SEG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == jwst_pkg::CFG_MIN_SEG) begin
        cfg.min_seg <= cfg_data[jwst_pkg::SEG_W-1:0];
      end else begin
        cfg.inv_rate[cfg_index] <= cfg_data[jwst_pkg::RATE_W-1:0];
      end
    end
  end

endmodule

>>> sv/jwst_delta_stage.sv
// Input register stage: keeps the previous waypoint and registers absolute joint moves.
module jwst_delta_stage #(
  parameter int NUM_JOINTS = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_first,
  input  logic [jwst_pkg::S_TDATA_W-1:0] in_pos,
  output logic                            out_valid,
  input  logic                            out_ready,
  output jwst_pkg::delta_item_t           out_item
);

  logic signed [jwst_pkg::POS_W-1:0]   prev_pos [NUM_JOINTS];
  logic signed [jwst_pkg::POS_W-1:0]   pos      [NUM_JOINTS];
  logic signed [jwst_pkg::POS_W:0]     diff     [NUM_JOINTS];
  logic        [jwst_pkg::POS_W-1:0]   abs_diff [NUM_JOINTS];
  jwst_pkg::delta_item_t               item_next;
  logic                                take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_joint
    assign pos[j]  = in_pos[j*jwst_pkg::POS_W +: jwst_pkg::POS_W];
    assign diff[j] = {pos[j][jwst_pkg::POS_W-1], pos[j]}
                   - {prev_pos[j][jwst_pkg::POS_W-1], prev_pos[j]};
    // |diff| never exceeds 65535, so the sign bit drops out
    assign abs_diff[j] = diff[j][jwst_pkg::POS_W] ? jwst_pkg::POS_W'(-diff[j])
                                                   : diff[j][jwst_pkg::POS_W-1:0];
  end

  // unused joint lanes stay at zero
  always_comb begin
    item_next.first     = in_first;
    item_next.abs_delta = '0;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      item_next.abs_delta[j] = abs_diff[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int j = 0; j < NUM_JOINTS; j++) begin
        prev_pos[j] <= '0;
      end
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (take) begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
          prev_pos[j] <= pos[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= item_next;
    end
  end

endmodule

>>> sv/jwst_time_stage.sv
// Result stage: joint times, segment maximum, running time and the output register.
module jwst_time_stage #(
  parameter int NUM_JOINTS = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  jwst_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  jwst_pkg::delta_item_t          in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [jwst_pkg::SEG_W-1:0]    out_seg,
  output logic [jwst_pkg::TIME_W-1:0]   out_time
);

  logic [jwst_pkg::PROD_W-1:0] prod     [NUM_JOINTS];
  logic [jwst_pkg::SEG_W-1:0]  jt       [NUM_JOINTS];
  logic [jwst_pkg::SEG_W-1:0]  seg_max;
  logic [jwst_pkg::SEG_W-1:0]  seg_clamp;
  logic [jwst_pkg::SEG_W-1:0]  seg_next;
  logic [jwst_pkg::TIME_W:0]   sum;
  logic [jwst_pkg::TIME_W-1:0] elapsed;
  logic [jwst_pkg::TIME_W-1:0] elapsed_next;
  logic                        take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // 16x16 product in 2^-24 s; floor to 2^-12 s stays below 2^20
  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_joint
    assign prod[j] = jwst_pkg::PROD_W'(in_item.abs_delta[j])
                   * jwst_pkg::PROD_W'(cfg.inv_rate[j]);
    assign jt[j]   = prod[j][jwst_pkg::FRAC_BITS +: jwst_pkg::SEG_W];
  end

  always_comb begin
    seg_max = '0;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      if (jt[j] > seg_max) begin
        seg_max = jt[j];
      end
    end
  end

  always_comb begin
    seg_clamp = (seg_max < cfg.min_seg) ? cfg.min_seg : seg_max;
    sum       = {1'b0, elapsed} + {{(jwst_pkg::TIME_W + 1 - jwst_pkg::SEG_W){1'b0}}, seg_clamp};
    if (in_item.first) begin
      seg_next     = '0;
      elapsed_next = '0;
    end else begin
      seg_next     = seg_clamp;
      elapsed_next = sum[jwst_pkg::TIME_W] ? '1 : sum[jwst_pkg::TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      elapsed   <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (take) begin
        elapsed <= elapsed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_seg  <= seg_next;
      out_time <= elapsed_next;
    end
  end

endmodule

>>> sv/joint_waypoint_segment_timer_unit.sv
// Top level of the joint waypoint segment timer.
// Pipeline: two register stages, the delta stage and then the result stage.
// Throughput: one waypoint per cycle while m_axis_tready is high; the running time updates
// as each item enters the result register, so back-to-back items chain with no bubble.
// Reset (rst, synchronous): previous waypoint and running time clear to zero, inverse
// rates return to 4096 (1 s/rad), minimum segment time to 41; both stages empty.
module joint_waypoint_segment_timer_unit #(
  parameter int NUM_JOINTS = 7
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [jwst_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // joint_pos_0 .. joint_pos_6
  input  logic [0:0]                       s_axis_tuser,  // first_point
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [jwst_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // segment_time, total time, pad
  input  logic                             cfg_we,
  input  logic [jwst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jwst_pkg::CFG_DATA_W-1:0] cfg_data
);

  jwst_pkg::cfg_t                cfg;
  jwst_pkg::delta_item_t         d_item;
  logic                          d_valid;
  logic                          d_ready;
  logic [jwst_pkg::SEG_W-1:0]   seg;
  logic [jwst_pkg::TIME_W-1:0]  time_total;

  jwst_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jwst_delta_stage #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_delta (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_first  (s_axis_tuser[0]),
    .in_pos    (s_axis_tdata),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_item  (d_item)
  );

  jwst_time_stage #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_time (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_item   (d_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_seg   (seg),
    .out_time  (time_total)
  );

  assign m_axis_tdata = {{(jwst_pkg::M_TDATA_W - jwst_pkg::SEG_W - jwst_pkg::TIME_W){1'b0}},
                         time_total, seg};

endmodule
